// ===== sv/bitmap_page_allocator_assert.svh =====
// Assertion macros shared by the checker of the bitmap page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, off while reset is applied.
`define BPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bitmap page allocator: check failed");

// Next-cycle implication, off while reset is applied.
`define BPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bitmap page allocator: check failed");

`endif

// ===== sv/bpa_pkg.sv =====
// Types, constants and codes shared by the bitmap page allocator modules.
`timescale 1ns / 1ps
package bpa_pkg;

    localparam int NUM_PAGES_DEF   = 4096;
    localparam int MAX_SCATTER_DEF = 64;
    localparam int REG_W           = 13;
    localparam int MAX_REGION      = 8192;
    localparam int IDX_W           = 12;
    localparam int CNT_W           = 13;
    localparam int PW              = 14;
    localparam int WORD_BITS       = 8;
    localparam int WB_W            = 3;

    localparam logic [REG_W-1:0] REGION_RST = 13'd4096;

    localparam logic [1:0] OP_FIT     = 2'd0;
    localparam logic [1:0] OP_SCATTER = 2'd1;
    localparam logic [1:0] OP_FREE    = 2'd2;
    localparam logic [1:0] OP_MARK    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    localparam logic [1:0] K_BAD    = 2'd0;
    localparam logic [1:0] K_NOFREE = 2'd1;
    localparam logic [1:0] K_RANGE  = 2'd2;
    localparam logic [1:0] K_TAKE   = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] start_page;
        logic [CNT_W-1:0] page_count;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] page_index;
        logic [CNT_W-1:0] pages_done;
        logic [CNT_W-1:0] used_pages;
        logic             last;
    } t_rsp;

    typedef struct packed {
        logic       clr_step;
        logic       latch;
        logic       addr_zero;
        logic       addr_lo;
        logic       fit_step;
        logic       set_mark;
        logic       rng_step;
        logic       cnt_step;
        logic       take;
        logic       addr_inc;
        logic       emit;
        logic [1:0] kind;
    } t_cmd;

    typedef struct packed {
        logic       clr_end;
        logic       bad;
        logic       empty;
        logic [1:0] op;
        logic       fit_found;
        logic       fit_end;
        logic       rng_end;
        logic       cnt_end;
        logic       enough;
        logic       have_free;
        logic       take_last;
        logic       out_free;
    } t_sts;

endpackage

// ===== sv/bpa_ctrl.sv =====
// Sequencing state machine of the bitmap page allocator.
`timescale 1ns / 1ps
module bpa_ctrl import bpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_FIT_RD  = 4'd3;
    localparam logic [3:0] S_FIT     = 4'd4;
    localparam logic [3:0] S_MARK    = 4'd5;
    localparam logic [3:0] S_RNG_RD  = 4'd6;
    localparam logic [3:0] S_RNG     = 4'd7;
    localparam logic [3:0] S_CNT_RD  = 4'd8;
    localparam logic [3:0] S_CNT     = 4'd9;
    localparam logic [3:0] S_CNT_CHK = 4'd10;
    localparam logic [3:0] S_TAKE_RD = 4'd11;
    localparam logic [3:0] S_TAKE    = 4'd12;
    localparam logic [3:0] S_BAD     = 4'd13;
    localparam logic [3:0] S_NOFREE  = 4'd14;
    localparam logic [3:0] S_DONE    = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.bad) begin
                    n_state = S_BAD;
                end else if (i_sts.op == OP_FIT) begin
                    o_cmd.addr_zero = 1'b1;
                    n_state         = S_FIT_RD;
                end else if (i_sts.op == OP_SCATTER) begin
                    o_cmd.addr_zero = 1'b1;
                    n_state         = S_CNT_RD;
                end else if (i_sts.empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.addr_lo = 1'b1;
                    n_state       = S_RNG_RD;
                end
            end
            S_FIT_RD: n_state = S_FIT;
            S_FIT: begin
                o_cmd.fit_step = 1'b1;
                if (i_sts.fit_found) begin
                    n_state = S_MARK;
                end else if (i_sts.fit_end) begin
                    n_state = S_NOFREE;
                end else begin
                    n_state = S_FIT_RD;
                end
            end
            S_MARK: begin
                o_cmd.set_mark = 1'b1;
                n_state        = S_RNG_RD;
            end
            S_RNG_RD: n_state = S_RNG;
            S_RNG: begin
                o_cmd.rng_step = 1'b1;
                n_state        = i_sts.rng_end ? S_DONE : S_RNG_RD;
            end
            S_CNT_RD: n_state = S_CNT;
            S_CNT: begin
                o_cmd.cnt_step = 1'b1;
                n_state        = i_sts.cnt_end ? S_CNT_CHK : S_CNT_RD;
            end
            S_CNT_CHK: begin
                if (i_sts.enough) begin
                    o_cmd.addr_zero = 1'b1;
                    n_state         = S_TAKE_RD;
                end else begin
                    n_state = S_NOFREE;
                end
            end
            S_TAKE_RD: n_state = S_TAKE;
            S_TAKE: begin
                if (i_sts.have_free) begin
                    if (i_sts.out_free) begin
                        o_cmd.take = 1'b1;
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = K_TAKE;
                        if (i_sts.take_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    o_cmd.addr_inc = 1'b1;
                    n_state        = S_TAKE_RD;
                end
            end
            S_BAD, S_NOFREE, S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = (r_state == S_BAD)    ? K_BAD :
                                 (r_state == S_NOFREE) ? K_NOFREE : K_RANGE;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/bpa_dp.sv =====
// Bitmap memory, scan logic, counters and result register of the page allocator.
`timescale 1ns / 1ps
module bpa_dp import bpa_pkg::*; #(
    parameter int NUM_PAGES   = NUM_PAGES_DEF,
    parameter int MAX_SCATTER = MAX_SCATTER_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [REG_W-1:0] i_cfg_wdata,
    input  t_req             i_in,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic             o_valid,
    input  logic             i_stall,
    output t_rsp             o_out
);

    localparam int EFF_PAGES = (NUM_PAGES < MAX_REGION) ? NUM_PAGES : MAX_REGION;
    localparam int DEPTH     = (EFF_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW        = $clog2(MAX_SCATTER + 1);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [AW-1:0]        r_addr;
    logic [WORD_BITS-1:0] r_q;
    logic [WORD_BITS-1:0] r_word;
    logic                 r_word_ok;
    logic [REG_W-1:0]     r_region;
    logic [1:0]           r_op;
    logic [CNT_W-1:0]     r_count;
    logic [PW-1:0]        r_lo;
    logic [PW-1:0]        r_hi;
    logic                 r_want;
    logic                 r_bad;
    logic                 r_empty;
    logic [CNT_W-1:0]     r_run;
    logic [PW-1:0]        r_run_start;
    logic [CNT_W-1:0]     r_nfree;
    logic [CNT_W-1:0]     r_used;
    logic [TW-1:0]        r_taken;
    logic                 r_out_valid;
    t_rsp                 r_out;

    logic [PW-1:0]        reg_end;
    logic [PW-1:0]        base;
    logic [PW-1:0]        base_next;
    logic [PW-1:0]        start_x;
    logic [PW-1:0]        count_x;
    logic [PW-1:0]        n_len;
    logic                 n_bad;
    logic [CNT_W-1:0]     n_run;
    logic [PW-1:0]        n_run_start;
    logic                 n_found;
    logic [WORD_BITS-1:0] m_reg;
    logic [WORD_BITS-1:0] m_rng;
    logic [WORD_BITS-1:0] n_wr;
    logic [WORD_BITS-1:0] chg;
    logic [CNT_W-1:0]     delta;
    logic [CNT_W-1:0]     n_used;
    logic [WORD_BITS-1:0] w_take;
    logic [WORD_BITS-1:0] cand;
    logic [WB_W-1:0]      sel;
    logic [WORD_BITS-1:0] sel_bit;
    logic [PW-1:0]        take_pos;
    logic                 take_last;
    logic                 addr_move;

    assign reg_end   = (PW'(r_region) > PW'(EFF_PAGES)) ? PW'(EFF_PAGES) : PW'(r_region);
    assign base      = PW'({r_addr, {WB_W{1'b0}}});
    assign base_next = base + PW'(WORD_BITS);

    // Clipped length of a range operation.
    assign start_x = PW'(i_in.start_page);
    assign count_x = PW'(i_in.page_count);
    always_comb begin
        n_len = '0;
        if (start_x < reg_end) begin
            n_len = ((reg_end - start_x) < count_x) ? (reg_end - start_x) : count_x;
        end
        case (i_in.op)
            OP_FIT:     n_bad = (i_in.page_count == '0);
            OP_SCATTER: n_bad = (i_in.page_count == '0) || (count_x > PW'(MAX_SCATTER));
            default:    n_bad = (start_x >= reg_end);
        endcase
    end

    // First-fit run tracking over the eight pages of one word.
    always_comb begin
        logic [PW-1:0] pos;
        n_run       = r_run;
        n_run_start = r_run_start;
        n_found     = 1'b0;
        for (int b = 0; b < WORD_BITS; b++) begin
            pos = base + PW'(b);
            if (!n_found && (pos < reg_end)) begin
                if (r_q[b]) begin
                    n_run = '0;
                end else begin
                    if (n_run == '0) begin
                        n_run_start = pos;
                    end
                    n_run = n_run + CNT_W'(1);
                    if (n_run >= r_count) begin
                        n_found = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        logic [PW-1:0] pos;
        for (int b = 0; b < WORD_BITS; b++) begin
            pos      = base + PW'(b);
            m_reg[b] = (pos < reg_end);
            m_rng[b] = (pos >= r_lo) && (pos < r_hi);
        end
    end

    assign n_wr   = r_want ? (r_q | m_rng) : (r_q & ~m_rng);
    assign chg    = m_rng & (r_want ? ~r_q : r_q);
    assign delta  = CNT_W'($countones(chg));
    assign n_used = r_want ? (r_used + delta) : ((r_used >= delta) ? (r_used - delta) : '0);

    // Lowest free page of the word for scattered allocation.
    assign w_take = r_word_ok ? r_word : r_q;
    assign cand   = ~w_take & m_reg;
    always_comb begin
        sel = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (cand[b]) begin
                sel = WB_W'(b);
            end
        end
    end
    assign sel_bit   = WORD_BITS'(1) << sel;
    assign take_pos  = base + PW'(sel);
    assign take_last = ((CNT_W'(r_taken) + CNT_W'(1)) == r_count);

    assign addr_move = i_cmd.clr_step | i_cmd.fit_step | i_cmd.rng_step | i_cmd.cnt_step
                     | i_cmd.addr_inc | i_cmd.addr_zero | i_cmd.addr_lo | i_cmd.set_mark;

    assign o_sts.clr_end   = (r_addr == AW'(DEPTH - 1));
    assign o_sts.bad       = r_bad;
    assign o_sts.empty     = r_empty;
    assign o_sts.op        = r_op;
    assign o_sts.fit_found = n_found;
    assign o_sts.fit_end   = (base_next >= reg_end);
    assign o_sts.rng_end   = (base_next >= r_hi);
    assign o_sts.cnt_end   = (base_next >= reg_end);
    assign o_sts.enough    = (r_nfree >= r_count);
    assign o_sts.have_free = |cand;
    assign o_sts.take_last = take_last;
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    // Bitmap memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_addr] <= '0;
        end else if (i_cmd.rng_step) begin
            r_mem[r_addr] <= n_wr;
        end else if (i_cmd.take) begin
            r_mem[r_addr] <= w_take | sel_bit;
        end
        r_q <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_region    <= REGION_RST;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_region <= i_cfg_wdata;
            end
            if (i_cmd.addr_zero) begin
                r_addr <= '0;
            end else if (i_cmd.addr_lo) begin
                r_addr <= AW'(r_lo >> WB_W);
            end else if (i_cmd.set_mark) begin
                r_addr <= AW'(r_run_start >> WB_W);
            end else if (addr_move) begin
                r_addr <= r_addr + AW'(1);
            end
            if (i_cmd.rng_step) begin
                r_used <= n_used;
            end else if (i_cmd.take) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (addr_move) begin
            r_word_ok <= 1'b0;
        end else if (i_cmd.take) begin
            r_word_ok <= 1'b1;
        end
        if (i_cmd.take) begin
            r_word  <= w_take | sel_bit;
            r_taken <= r_taken + TW'(1);
        end
        if (i_cmd.latch) begin
            r_op    <= i_in.op;
            r_count <= i_in.page_count;
            r_lo    <= start_x;
            r_hi    <= start_x + n_len;
            r_want  <= (i_in.op == OP_MARK);
            r_bad   <= n_bad;
            r_empty <= (n_len == '0);
            r_run   <= '0;
            r_nfree <= '0;
            r_taken <= '0;
        end
        if (i_cmd.fit_step) begin
            r_run       <= n_run;
            r_run_start <= n_run_start;
        end
        if (i_cmd.set_mark) begin
            r_lo   <= r_run_start;
            r_hi   <= r_run_start + PW'(r_count);
            r_want <= 1'b1;
        end
        if (i_cmd.cnt_step) begin
            r_nfree <= r_nfree + CNT_W'($countones(~r_q & m_reg));
        end
        if (i_cmd.emit) begin
            case (i_cmd.kind)
                K_BAD: begin
                    r_out <= '{status: ST_BAD, page_index: '0, pages_done: '0,
                               used_pages: r_used, last: 1'b1};
                end
                K_NOFREE: begin
                    r_out <= '{status: ST_NOFREE, page_index: '0, pages_done: '0,
                               used_pages: r_used, last: 1'b1};
                end
                K_RANGE: begin
                    r_out <= '{status: ST_OK, page_index: r_lo[IDX_W-1:0],
                               pages_done: CNT_W'(r_hi - r_lo),
                               used_pages: r_used, last: 1'b1};
                end
                default: begin
                    r_out <= '{status: ST_OK, page_index: take_pos[IDX_W-1:0],
                               pages_done: CNT_W'(r_taken) + CNT_W'(1),
                               used_pages: r_used + CNT_W'(1), last: take_last};
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

// ===== sv/bitmap_page_allocator.sv =====
// Top level of the first-fit bitmap page allocator.
//
// Requests arrive on the input channel (i_valid / o_stall, payload i_in) and
// results leave on the output channel (o_valid / i_stall, payload o_out).
// A word moves when valid is high and stall is low at a rising clock edge.
// One request is worked on at a time; o_stall is low only while the block
// waits for a new request. Ops 0, 2 and 3 give one result word, op 1 gives
// one result word per page taken, the final one flagged by last.
// The bitmap lives in a memory of 8-page words; each word is scanned by a
// registered read followed by a processing step. A first-fit search scans
// words from the region start up to the run found, then marks the words of
// the run; a scattered request first counts free pages over the whole region,
// then takes pages word by word. Range frees and marks touch only the words in
// the range. After reset a clearing pass writes every bitmap word to zero, one
// word per cycle, with o_stall held high meanwhile. The region register is
// written through i_cfg_we / i_cfg_wdata; the user must write it only while
// idle, as the block itself does not enforce this. A stalled result stays in
// the output register; the block then waits before producing its next result
// word.
`timescale 1ns / 1ps
module bitmap_page_allocator import bpa_pkg::*; #(
    parameter int NUM_PAGES   = NUM_PAGES_DEF,
    parameter int MAX_SCATTER = MAX_SCATTER_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [REG_W-1:0] i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_req             i_in,
    output logic             o_valid,
    input  logic             i_stall,
    output t_rsp             o_out
);

    // Commands flow from the sequencer to the datapath, status flows back.
    t_cmd cmd;
    t_sts sts;

    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bpa_dp #(
        .NUM_PAGES   (NUM_PAGES),
        .MAX_SCATTER (MAX_SCATTER)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out)
    );

endmodule

// ===== sv/bpa_checker.sv =====
// Port-level checks of the bitmap page allocator, bound to the top level.
`timescale 1ns / 1ps
`include "bitmap_page_allocator_assert.svh"
module bpa_checker import bpa_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_rsp o_out
);

    // A stalled result word is held unchanged.
    `BPA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out))

    // Only defined status codes leave the block.
    `BPA_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_valid, o_out.status == ST_OK || o_out.status == ST_NOFREE || o_out.status == ST_BAD)

    // A failed request ends with one result carrying no pages.
    `BPA_ASSERT_IMP(a_fail_word, i_clk, i_rst_n, o_valid && o_out.status != ST_OK, o_out.last && o_out.page_index == '0 && o_out.pages_done == '0)

    // Once a request is taken the block is busy on the next cycle.
    `BPA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);

// ===== bench/tb_bitmap_page_allocator.sv =====
// Self-checking testbench for the first-fit bitmap page allocator.
`timescale 1ns / 1ps
module tb_bitmap_page_allocator;
    import bpa_pkg::*;

    localparam int NPAGES   = 4096;
    localparam int NSCATTER = 64;
    localparam int LIMIT    = 8000000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [REG_W-1:0] i_cfg_wdata;
    logic             i_valid;
    logic             o_stall;
    t_req             i_in;
    logic             o_valid;
    logic             i_stall;
    t_rsp             o_out;

    bitmap_page_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out)
    );

    // The clock runs at a 20 ns period.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // The bench keeps its own copy of the bitmap, the used count and the
    // region size. Every accepted request word updates this copy and pushes
    // the result words that the block must later return.
    bit          shadow_map [NPAGES];
    int unsigned shadow_used;
    int unsigned shadow_region;
    t_rsp        pending_rsp [$];
    int          errors;
    int          cycle_count;
    bit          hold_quiet;
    bit          hold_long;

    function automatic t_rsp make_rsp(logic [1:0] st, int unsigned idx,
                                      int unsigned done, bit fin);
        t_rsp r;
        r.status     = st;
        r.page_index = idx[IDX_W-1:0];
        r.pages_done = done[CNT_W-1:0];
        r.used_pages = shadow_used[CNT_W-1:0];
        r.last       = fin;
        return r;
    endfunction

    // Applies one request to the shadow state and queues its results.
    function automatic void predict_alloc(t_req rq);
        int unsigned reg_n;
        int unsigned cnt;
        int unsigned run;
        int unsigned run_at;
        int unsigned nfree;
        int unsigned taken;
        int unsigned n;
        bit          want;
        reg_n = (shadow_region < NPAGES) ? shadow_region : NPAGES;
        cnt   = rq.page_count;
        case (rq.op)
            OP_FIT: begin
                if (cnt == 0) begin
                    pending_rsp.push_back(make_rsp(ST_BAD, 0, 0, 1'b1));
                end else begin
                    run    = 0;
                    run_at = 0;
                    for (int unsigned i = 0; i < reg_n; i++) begin
                        if (shadow_map[i]) begin
                            run = 0;
                        end else begin
                            if (run == 0) run_at = i;
                            run++;
                            if (run >= cnt) break;
                        end
                    end
                    if (run < cnt) begin
                        pending_rsp.push_back(make_rsp(ST_NOFREE, 0, 0, 1'b1));
                    end else begin
                        for (int unsigned i = run_at; i < run_at + cnt; i++)
                            shadow_map[i] = 1'b1;
                        shadow_used += cnt;
                        pending_rsp.push_back(make_rsp(ST_OK, run_at, cnt, 1'b1));
                    end
                end
            end
            OP_SCATTER: begin
                nfree = 0;
                for (int unsigned i = 0; i < reg_n; i++)
                    if (!shadow_map[i]) nfree++;
                if (cnt == 0 || cnt > NSCATTER) begin
                    pending_rsp.push_back(make_rsp(ST_BAD, 0, 0, 1'b1));
                end else if (nfree < cnt) begin
                    pending_rsp.push_back(make_rsp(ST_NOFREE, 0, 0, 1'b1));
                end else begin
                    taken = 0;
                    for (int unsigned i = 0; i < reg_n && taken < cnt; i++) begin
                        if (!shadow_map[i]) begin
                            shadow_map[i] = 1'b1;
                            shadow_used++;
                            taken++;
                            pending_rsp.push_back(make_rsp(ST_OK, i, taken,
                                                           taken == cnt));
                        end
                    end
                end
            end
            default: begin
                want = (rq.op == OP_MARK);
                if (rq.start_page >= reg_n) begin
                    pending_rsp.push_back(make_rsp(ST_BAD, 0, 0, 1'b1));
                end else begin
                    n = reg_n - rq.start_page;
                    if (cnt < n) n = cnt;
                    for (int unsigned i = rq.start_page; i < rq.start_page + n; i++) begin
                        if (shadow_map[i] != want) begin
                            shadow_map[i] = want;
                            if (want) shadow_used++;
                            else if (shadow_used > 0) shadow_used--;
                        end
                    end
                    pending_rsp.push_back(make_rsp(ST_OK, rq.start_page, n, 1'b1));
                end
            end
        endcase
    endfunction

    // Directed table. A row with has_exp set also carries the result that
    // can be read straight off the spec; every row goes through the
    // predictor as well.
    typedef struct {
        logic [1:0]  op;
        int unsigned start;
        int unsigned count;
        bit          has_exp;
        logic [1:0]  exp_status;
    } t_row;

    t_row directed_rows [] = '{
        '{OP_FIT,     0,    0,    1'b1, ST_BAD},     // zero count
        '{OP_SCATTER, 0,    0,    1'b1, ST_BAD},     // zero count
        '{OP_SCATTER, 0,    65,   1'b1, ST_BAD},     // beyond scatter cap
        '{OP_SCATTER, 0,    8191, 1'b1, ST_BAD},
        '{OP_FIT,     0,    1,    1'b1, ST_OK},      // first page after reset
        '{OP_FIT,     0,    7,    1'b0, ST_OK},
        '{OP_SCATTER, 0,    64,   1'b0, ST_OK},
        '{OP_FREE,    3,    5,    1'b0, ST_OK},      // hole in the middle
        '{OP_FIT,     0,    5,    1'b0, ST_OK},
        '{OP_SCATTER, 0,    3,    1'b0, ST_OK},
        '{OP_MARK,    4095, 1,    1'b0, ST_OK},      // top page
        '{OP_MARK,    4000, 8191, 1'b0, ST_OK},      // clipped at region end
        '{OP_FREE,    10,   0,    1'b0, ST_OK},      // empty range
        '{OP_FIT,     0,    4096, 1'b1, ST_NOFREE},
        '{OP_FIT,     0,    8191, 1'b1, ST_NOFREE},
        '{OP_FREE,    0,    4096, 1'b0, ST_OK},      // free everything
        '{OP_FIT,     0,    4096, 1'b0, ST_OK},      // whole region
        '{OP_SCATTER, 0,    1,    1'b1, ST_NOFREE},
        '{OP_FREE,    2730, 1365, 1'b0, ST_OK},
        '{OP_MARK,    1365, 2730, 1'b0, ST_OK},
        '{OP_FREE,    0,    4096, 1'b0, ST_OK}
    };

    // Drives one request word and holds it until the block takes it. Valid
    // stays high after the accepting edge so that a following request can go
    // out back to back; an idle gap or a drain drops it.
    task automatic send_request(t_req rq);
        while ($urandom_range(99) < 10 && !hold_quiet) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= rq;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_alloc(rq);
    endtask

    // Waits until every queued result has come back, then lets the block
    // finish any tail work before a register write.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_region(int unsigned pages);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= pages[REG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_region = pages;
    endtask

    // Random requests, weighted toward small sizes so the run stays short.
    task automatic random_requests(int n);
        t_req rq;
        int   pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            rq.op         = $urandom_range(3);
            rq.start_page = $urandom;
            if (pick < 70)      rq.page_count = $urandom_range(1, 24);
            else if (pick < 85) rq.page_count = $urandom_range(0, 80);
            else if (pick < 95) rq.page_count = $urandom_range(0, 600);
            else                rq.page_count = $urandom;
            if (rq.op inside {OP_FREE, OP_MARK} && pick < 80 && shadow_region > 1)
                rq.start_page = $urandom_range(shadow_region - 1);
            send_request(rq);
        end
    endtask

    // Result side: random stall, one long hold-off so the block backs up,
    // and a comparison of every result word with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= hold_long || (!hold_quiet && $urandom_range(99) < 10);
            if (o_valid && !i_stall) begin
                if (pending_rsp.size() == 0) begin
                    $error("unexpected result word: %p", o_out);
                    errors++;
                end else begin
                    t_rsp exp_rsp;
                    exp_rsp = pending_rsp.pop_front();
                    if (o_out.status !== exp_rsp.status) begin
                        $error("status: expected %0d, got %0d",
                               exp_rsp.status, o_out.status);
                        errors++;
                    end
                    if (o_out.page_index !== exp_rsp.page_index) begin
                        $error("page_index: expected %0d, got %0d",
                               exp_rsp.page_index, o_out.page_index);
                        errors++;
                    end
                    if (o_out.pages_done !== exp_rsp.pages_done) begin
                        $error("pages_done: expected %0d, got %0d",
                               exp_rsp.pages_done, o_out.pages_done);
                        errors++;
                    end
                    if (o_out.used_pages !== exp_rsp.used_pages) begin
                        $error("used_pages: expected %0d, got %0d",
                               exp_rsp.used_pages, o_out.used_pages);
                        errors++;
                    end
                    if (o_out.last !== exp_rsp.last) begin
                        $error("last: expected %0d, got %0d",
                               exp_rsp.last, o_out.last);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog on total cycles.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Long receiver hold-off, counted in its own process.
    initial begin
        hold_long = 1'b0;
        wait (hold_quiet);
        @(posedge i_clk);
        hold_long = 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_long = 1'b0;
    end

    initial begin
        t_req rq;
        errors      = 0;
        cycle_count = 0;
        hold_quiet  = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_in        = '0;
        shadow_used   = 0;
        shadow_region = REGION_RST;
        foreach (shadow_map[i]) shadow_map[i] = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows; the quick-look ones give a single result word, the
        // newest expectation, whose status must match the obvious answer.
        foreach (directed_rows[r]) begin
            rq.op         = directed_rows[r].op;
            rq.start_page = directed_rows[r].start[IDX_W-1:0];
            rq.page_count = directed_rows[r].count[CNT_W-1:0];
            send_request(rq);
            if (directed_rows[r].has_exp &&
                pending_rsp[$].status !== directed_rows[r].exp_status) begin
                $error("status: expected %0d, got %0d (row %0d predictor)",
                       directed_rows[r].exp_status, pending_rsp[$].status, r);
                errors++;
            end
        end

        // Random phases over several region sizes, the extremes included.
        random_requests(120);
        set_region(1);
        random_requests(40);
        set_region(0);             // empty region, every op fails
        random_requests(20);
        set_region(100);
        random_requests(100);
        set_region(8191);          // clamps to the full map
        // Busy stretch with the receiver held off so the block fills up.
        hold_quiet = 1'b1;
        random_requests(60);
        hold_quiet = 1'b0;
        set_region(37);
        random_requests(80);
        set_region(4096);
        random_requests(80);

        drain_results();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
